FILE: rtl/core/utlm_pkg.sv
package utlm_pkg;

	typedef enum logic [2:0] {
		CMD_BEGIN   = 3'd0,
		CMD_END     = 3'd1,
		CMD_RELEASE = 3'd2,
		CMD_SUBMIT  = 3'd3,
		CMD_POLL    = 3'd4,
		CMD_REPORT  = 3'd5,
		CMD_READ    = 3'd6,
		CMD_NONE    = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP1,
		S_SCAN,
		S_PREP2,
		S_SWEEP,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		M_CLR,
		M_UPD,
		M_RPT
	} sweep_mode_t;

	typedef struct packed {
		logic        clr;
		logic        is_max;
		logic [31:0] opnd;
	} alu_op_t;

	localparam logic [1:0] EP_BULK = 2'd2;

endpackage

FILE: rtl/core/utlm_ram.sv
module utlm_ram #(
	parameter int DEPTH = 41,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/utlm_alu.sv
module utlm_alu (
	input  utlm_pkg::alu_op_t op,
	input  logic [31:0]       old,
	output logic [31:0]       result
);
	import utlm_pkg::*;

	always_comb begin
		if (op.clr) begin
			result = '0;
		end else if (op.is_max) begin
			result = (op.opnd > old) ? op.opnd : old;
		end else begin
			result = old + op.opnd;
		end
	end

endmodule

FILE: rtl/core/usb_tx_transfer_lifetime_monitor.sv
// Bulk OUT transfer lifetime monitor. Every input transaction is one event and
// yields exactly one output transaction (read_value, live_count). Events are
// handled one at a time. An end or release that scans the channel table for
// pending transfers does so before the counter sweep, and a result still
// waiting on m_tready holds the event in its final state. Each event passes
// through the counter store, a single-port-write memory that one shared
// add/max unit sweeps once per event. After reset a clearing pass zeroes the
// counter and snapshot stores before the first event is taken. The output is
// registered, so a new event is taken while a result waits.
module usb_tx_transfer_lifetime_monitor #(
	parameter int NUM_CHANNELS = 16,
	parameter int NUM_STATES   = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cmd, timestamp, channel, direction, ep_type, address, length, status,
	// counter_index, zero pad
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// read_value, live_count, zero pad
	output logic [39:0]  m_tdata
);
	import utlm_pkg::*;

	localparam int NC = 33 + NUM_STATES;
	localparam int NM = NC - 2;
	localparam int AW = $clog2(NC);
	localparam int KW = $clog2(NC + 1);
	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int LW = $clog2(NUM_CHANNELS + 1);

	localparam int C_LCALLS    = 0;
	localparam int C_LOK       = 1;
	localparam int C_LERR      = 2;
	localparam int C_LBYTES    = 3;
	localparam int C_LCYC      = 4;
	localparam int C_LCYCMAX   = 5;
	localparam int C_LNONE     = 6;
	localparam int C_LONE      = 7;
	localparam int C_LMULTI    = 8;
	localparam int C_LSUBMITS  = 9;
	localparam int C_LTERMS    = 10;
	localparam int C_LPEND     = 11;
	localparam int C_RELS      = 12;
	localparam int C_ANOM      = 13;
	localparam int C_RPEND     = 14;
	localparam int C_RCYC      = 15;
	localparam int C_RCYCMAX   = 16;
	localparam int C_SCALLS    = 17;
	localparam int C_SERR      = 18;
	localparam int C_SBYTES    = 19;
	localparam int C_SSCOPED   = 20;
	localparam int C_SREPL     = 21;
	localparam int C_SEXACT    = 22;
	localparam int C_SRANGE    = 23;
	localparam int C_SINTERNAL = 24;
	localparam int C_TCALLS    = 25;
	localparam int C_TSTATE    = 26;
	localparam int C_TOTHER    = 26 + NUM_STATES;
	localparam int C_TCYC      = 27 + NUM_STATES;
	localparam int C_TCYCMAX   = 28 + NUM_STATES;
	localparam int C_POLLS     = 29 + NUM_STATES;
	localparam int C_IDLE      = 30 + NUM_STATES;

	state_t      state_q, state_nx;
	sweep_mode_t mode_q;

	cmd_t        cmd_q;
	logic [31:0] ts_q;
	logic [7:0]  ch_q;
	logic        dir_q;
	logic [1:0]  ept_q;
	logic [31:0] addr_q;
	logic [31:0] len_q;
	logic [7:0]  st_q;
	logic [5:0]  idx_q;

	logic        active_q [NUM_CHANNELS];
	logic [31:0] cst_q [NUM_CHANNELS];
	logic [31:0] ctag_q [NUM_CHANNELS];

	logic [31:0] sa_q, sl_q, sst_q, set_q, tag_q, ssc_q, stc_q;
	logic        open_q, rw_q;
	logic [LW-1:0] livenow_q, livemax_q;

	logic [31:0] el_q;
	logic [32:0] d1_q, d2_q;
	logic        pend_q;
	logic [CW-1:0] j_q;
	logic [NM-1:0] inc_q;
	logic [NM-1:0] inc_nx;
	logic [KW-1:0] k_q;
	logic [AW-1:0] addr_s1;
	logic          v_s1;

	logic [31:0] out_rv_q;
	logic [4:0]  out_lc_q;
	logic        m_tvalid_q;

	logic [15:0]   l16;
	logic          trk, sub_ok, poll_ok;
	logic [CW-1:0] cidx;
	logic [KW-1:0] limit;
	logic          fin_fire;
	logic          s_accept;
	logic [31:0]   base;

	logic          l_we, s_we;
	logic [AW-1:0] l_ra, s_ra;
	logic [31:0]   l_rd, s_rd, l_wd, s_wd;
	alu_op_t       op;
	logic [LW-1:0] livenow_nx;
	logic [31:0]   rv;

	assign l16      = len_q[15:0];
	assign trk      = ch_q < 8'(NUM_CHANNELS);
	assign cidx     = (state_q == S_SCAN) ? j_q : ch_q[CW-1:0];
	assign sub_ok   = (cmd_q == CMD_SUBMIT) && !dir_q && (ept_q == EP_BULK) && trk;
	assign poll_ok  = (cmd_q == CMD_POLL) && trk && active_q[cidx];
	assign limit    = (mode_q == M_UPD) ? KW'(NM) : KW'(NC);
	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign fin_fire = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_lc_q, out_rv_q};

	// counter stores
	assign l_ra = (k_q < KW'(NM)) ? AW'(k_q) : '0;
	assign s_ra = (idx_q < 6'(NC)) ? AW'(idx_q) : '0;
	assign l_we = v_s1 && (addr_s1 < AW'(NM));
	assign s_we = v_s1 && (mode_q != M_UPD);

	utlm_ram #(.DEPTH(NM), .AW(AW)) u_live (
		.clk(clk), .we(l_we), .waddr(addr_s1), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);

	utlm_ram #(.DEPTH(NC), .AW(AW)) u_snap (
		.clk(clk), .we(s_we), .waddr(addr_s1), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
	);

	utlm_alu u_alu (.op(op), .old(l_rd), .result(l_wd));

	always_comb begin
		op.clr    = (mode_q != M_UPD);
		op.is_max = 1'b0;
		op.opnd   = '0;
		if (inc_q[addr_s1]) begin
			op.opnd = 32'd1;
			if (addr_s1 == AW'(C_LBYTES)) begin
				op.opnd = sl_q;
			end else if (addr_s1 == AW'(C_LCYC) || addr_s1 == AW'(C_RCYC) ||
			             addr_s1 == AW'(C_TCYC)) begin
				op.opnd = el_q;
			end else if (addr_s1 == AW'(C_LCYCMAX) || addr_s1 == AW'(C_RCYCMAX) ||
			             addr_s1 == AW'(C_TCYCMAX)) begin
				op.opnd   = el_q;
				op.is_max = 1'b1;
			end else if (addr_s1 == AW'(C_LSUBMITS)) begin
				op.opnd = ssc_q;
			end else if (addr_s1 == AW'(C_LTERMS)) begin
				op.opnd = stc_q;
			end else if (addr_s1 == AW'(C_SBYTES)) begin
				op.opnd = {16'd0, l16};
			end
		end
	end

	always_comb begin
		if (mode_q == M_CLR) begin
			s_wd = '0;
		end else if (addr_s1 < AW'(NM)) begin
			s_wd = l_rd;
		end else if (addr_s1 == AW'(NM)) begin
			s_wd = 32'(livenow_q);
		end else begin
			s_wd = 32'(livemax_q);
		end
	end

	// event decode into counter increments
	always_comb begin
		inc_nx = '0;
		unique case (cmd_q)
			CMD_BEGIN: begin
				if (open_q || rw_q) inc_nx[C_ANOM] = 1'b1;
			end
			CMD_END: begin
				if (!open_q) begin
					inc_nx[C_ANOM] = 1'b1;
				end else begin
					inc_nx[C_LCALLS]   = 1'b1;
					inc_nx[C_LBYTES]   = 1'b1;
					inc_nx[C_LCYC]     = 1'b1;
					inc_nx[C_LCYCMAX]  = 1'b1;
					inc_nx[C_LSUBMITS] = 1'b1;
					inc_nx[C_LTERMS]   = 1'b1;
					inc_nx[C_LPEND]    = pend_q;
					if (st_q == 8'd0) inc_nx[C_LOK] = 1'b1;
					else inc_nx[C_LERR] = 1'b1;
					if (ssc_q == 32'd0) inc_nx[C_LNONE] = 1'b1;
					else if (ssc_q == 32'd1) inc_nx[C_LONE] = 1'b1;
					else inc_nx[C_LMULTI] = 1'b1;
				end
			end
			CMD_RELEASE: begin
				if (!rw_q) begin
					inc_nx[C_ANOM] = 1'b1;
				end else begin
					inc_nx[C_RELS]    = 1'b1;
					inc_nx[C_RCYC]    = 1'b1;
					inc_nx[C_RCYCMAX] = 1'b1;
					inc_nx[C_RPEND]   = pend_q;
				end
			end
			CMD_SUBMIT: begin
				if (sub_ok) begin
					inc_nx[C_SCALLS] = 1'b1;
					inc_nx[C_SBYTES] = 1'b1;
					if (st_q != 8'd0) begin
						inc_nx[C_SERR] = 1'b1;
					end else begin
						inc_nx[C_SREPL] = active_q[cidx];
						if (open_q) begin
							inc_nx[C_SSCOPED] = 1'b1;
							if (addr_q == sa_q && {16'd0, l16} == sl_q)
								inc_nx[C_SEXACT] = 1'b1;
							else if (!d1_q[32] && !d2_q[32] && d1_q[31:0] <= d2_q[31:0])
								inc_nx[C_SRANGE] = 1'b1;
							else
								inc_nx[C_SINTERNAL] = 1'b1;
						end
					end
				end
			end
			CMD_POLL: begin
				if (poll_ok) begin
					inc_nx[C_POLLS] = 1'b1;
					if (st_q == 8'd0) begin
						inc_nx[C_IDLE] = 1'b1;
					end else begin
						inc_nx[C_TCALLS]  = 1'b1;
						inc_nx[C_TCYC]    = 1'b1;
						inc_nx[C_TCYCMAX] = 1'b1;
						if (st_q >= 8'(NUM_STATES)) inc_nx[C_TOTHER] = 1'b1;
						for (int i = 0; i < NUM_STATES; i++) begin
							if (st_q == 8'(i)) inc_nx[C_TSTATE + i] = 1'b1;
						end
					end
				end
			end
			CMD_REPORT, CMD_READ, CMD_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (cmd_q)
			CMD_END:     base = sst_q;
			CMD_RELEASE: base = set_q;
			default:     base = cst_q[cidx];
		endcase
	end

	always_comb begin
		livenow_nx = livenow_q;
		if (sub_ok && st_q == 8'd0 && !active_q[cidx]) begin
			livenow_nx = livenow_q + LW'(1);
		end else if (poll_ok && st_q != 8'd0 && livenow_q != '0) begin
			livenow_nx = livenow_q - LW'(1);
		end
		rv = ((cmd_q == CMD_READ) && (idx_q < 6'(NC))) ? s_rd : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_accept) state_nx = S_PREP1;
			end
			S_PREP1: begin
				if ((cmd_q == CMD_END && open_q) || (cmd_q == CMD_RELEASE && rw_q))
					state_nx = S_SCAN;
				else
					state_nx = S_PREP2;
			end
			S_SCAN: begin
				if (j_q == CW'(NUM_CHANNELS - 1)) state_nx = S_PREP2;
			end
			S_PREP2: begin
				state_nx = S_SWEEP;
			end
			S_SWEEP: begin
				if (k_q == limit) state_nx = (mode_q == M_CLR) ? S_IDLE : S_FIN;
			end
			S_FIN: begin
				if (fin_fire) state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_CLR;
			k_q        <= '0;
			v_s1       <= 1'b0;
			j_q        <= '0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) active_q[i] <= 1'b0;
			sa_q       <= '0;
			sl_q       <= '0;
			sst_q      <= '0;
			set_q      <= '0;
			tag_q      <= '0;
			ssc_q      <= '0;
			stc_q      <= '0;
			open_q     <= 1'b0;
			rw_q       <= 1'b0;
			livenow_q  <= '0;
			livemax_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			v_s1 <= (state_q == S_SWEEP) && (k_q < limit);
			if (state_q == S_SWEEP && k_q < limit) k_q <= k_q + KW'(1);
			if (state_q == S_PREP1) begin
				j_q    <= '0;
				pend_q <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				j_q <= j_q + CW'(1);
				if (active_q[cidx] && ctag_q[cidx] == tag_q) pend_q <= 1'b1;
			end
			if (state_q == S_PREP2) begin
				k_q    <= '0;
				mode_q <= (cmd_q == CMD_REPORT) ? M_RPT : M_UPD;
			end
			if (fin_fire) begin
				m_tvalid_q <= 1'b1;
				livenow_q  <= livenow_nx;
				if (mode_q == M_RPT) begin
					livemax_q <= livenow_q;
				end else if (livenow_nx > livemax_q) begin
					livemax_q <= livenow_nx;
				end
				unique case (cmd_q)
					CMD_BEGIN: begin
						tag_q  <= (tag_q == 32'hFFFF_FFFF) ? 32'd1 : tag_q + 32'd1;
						sa_q   <= addr_q;
						sl_q   <= len_q;
						sst_q  <= ts_q;
						ssc_q  <= '0;
						stc_q  <= '0;
						open_q <= 1'b1;
						rw_q   <= 1'b0;
					end
					CMD_END: begin
						if (open_q) begin
							set_q  <= ts_q;
							open_q <= 1'b0;
							rw_q   <= 1'b1;
						end
					end
					CMD_RELEASE: begin
						if (rw_q) begin
							rw_q <= 1'b0;
							sa_q <= '0;
							sl_q <= '0;
						end
					end
					CMD_SUBMIT: begin
						if (sub_ok && st_q == 8'd0) begin
							active_q[cidx] <= 1'b1;
							if (open_q) ssc_q <= ssc_q + 32'd1;
						end
					end
					CMD_POLL: begin
						if (poll_ok && st_q != 8'd0) begin
							active_q[cidx] <= 1'b0;
							if (open_q && ctag_q[cidx] == tag_q) stc_q <= stc_q + 32'd1;
						end
					end
					CMD_REPORT, CMD_READ, CMD_NONE: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q  <= cmd_t'(s_tdata[2:0]);
			ts_q   <= s_tdata[34:3];
			ch_q   <= s_tdata[42:35];
			dir_q  <= s_tdata[43];
			ept_q  <= s_tdata[45:44];
			addr_q <= s_tdata[77:46];
			len_q  <= s_tdata[109:78];
			st_q   <= s_tdata[117:110];
			idx_q  <= s_tdata[123:118];
		end
		if (state_q == S_PREP1) begin
			el_q <= ts_q - base;
			d1_q <= {1'b0, addr_q} - {1'b0, sa_q};
			d2_q <= {1'b0, sl_q} - {17'd0, l16};
		end
		if (state_q == S_PREP2) inc_q <= inc_nx;
		if (state_q == S_SWEEP) addr_s1 <= AW'(k_q);
		if (fin_fire) begin
			out_rv_q <= rv;
			out_lc_q <= 5'(livenow_nx);
			if (sub_ok && st_q == 8'd0) begin
				cst_q[cidx]  <= ts_q;
				ctag_q[cidx] <= open_q ? tag_q : 32'd0;
			end
		end
	end

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		livenow_q <= LW'(NUM_CHANNELS))
		else $error("live count above channel count");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		livemax_q >= livenow_q)
		else $error("live peak below live count");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !l_we && !s_we)
		else $error("counter store written while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q == S_PREP1) && !s_tready)
		else $error("event not taken into processing");

endmodule
